// ===== src/sorted_array_priority_queue_macros.svh =====
// Assertion macros shared by the checker of the sorted-array priority queue.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, idle during reset.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, idle during reset.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/spq_pkg.sv =====
// Shared constants and types of the sorted-array priority queue.
`default_nettype none

package spq_pkg;

	localparam int unsigned CAPACITY = 128;
	localparam int unsigned ADDR_W = $clog2(CAPACITY);
	localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 8;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	// One result of a command.
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		status_t            status;
		logic [VALUE_W-1:0] removed_value;
	} result_t;

	// Access request from the sequencer to the store memory.
	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  waddr;
		logic [VALUE_W-1:0] wdata;
		logic               re;
		logic [ADDR_W-1:0]  raddr;
	} mem_req_t;

endpackage

`default_nettype wire

// ===== src/spq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module spq_ram #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned WIDTH = 32,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/spq_ctrl.sv =====
// Command sequencer: runs inserts and removes against the store memory.
`default_nettype none

module spq_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cmd_valid,
	output logic                             cmd_ready,
	input  wire logic                        cmd,
	input  wire logic [spq_pkg::VALUE_W-1:0] value,
	output spq_pkg::mem_req_t                mem_req,
	input  wire logic [spq_pkg::VALUE_W-1:0] mem_rdata,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output spq_pkg::result_t                 res
);

	localparam int unsigned AW = spq_pkg::ADDR_W;
	localparam int unsigned FW = spq_pkg::FILL_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_PUT,
		ST_POP,
		ST_RESP
	} state_t;

	state_t                       state_q;
	logic [FW-1:0]                fill_q;
	logic [AW-1:0]                pos_q;
	logic [spq_pkg::VALUE_W-1:0]  val_q;
	spq_pkg::result_t             res_q;

	logic accept;
	logic is_full;
	logic is_empty;
	logic greater;

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign is_full   = (fill_q == FW'(spq_pkg::CAPACITY));
	assign is_empty  = (fill_q == '0);
	assign greater   = $signed(mem_rdata) > $signed(val_q);
	assign res_valid = (state_q == ST_RESP);
	assign res       = res_q;

	always_comb begin
		mem_req       = '0;
		mem_req.waddr = pos_q;
		mem_req.wdata = val_q;
		mem_req.raddr = AW'(fill_q - FW'(1));
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == spq_pkg::CMD_INSERT) begin
						if (is_empty) begin
							mem_req.we    = 1'b1;
							mem_req.waddr = '0;
							mem_req.wdata = value;
						end else if (!is_full) begin
							mem_req.re = 1'b1;
						end
					end else if (!is_empty) begin
						mem_req.re = 1'b1;
					end
				end
			end
			ST_SHIFT: begin
				mem_req.we = 1'b1;
				if (greater) begin
					// Move the larger entry up and fetch the one below it.
					mem_req.wdata = mem_rdata;
					mem_req.re    = (pos_q > AW'(1));
					mem_req.raddr = pos_q - AW'(2);
				end
			end
			ST_PUT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = '0;
			end
			ST_POP, ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			pos_q   <= '0;
			val_q   <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_q.removed_value <= '0;
						val_q               <= value;
						if (cmd == spq_pkg::CMD_INSERT) begin
							if (is_full) begin
								res_q.status <= spq_pkg::STATUS_FULL;
								res_q.count  <= spq_pkg::COUNT_W'(fill_q);
								state_q      <= ST_RESP;
							end else begin
								res_q.status <= spq_pkg::STATUS_OK;
								fill_q       <= fill_q + FW'(1);
								res_q.count  <= spq_pkg::COUNT_W'(fill_q + FW'(1));
								pos_q        <= AW'(fill_q);
								state_q      <= is_empty ? ST_RESP : ST_SHIFT;
							end
						end else begin
							if (is_empty) begin
								res_q.status <= spq_pkg::STATUS_EMPTY;
								res_q.count  <= spq_pkg::COUNT_W'(fill_q);
								state_q      <= ST_RESP;
							end else begin
								res_q.status <= spq_pkg::STATUS_OK;
								fill_q       <= fill_q - FW'(1);
								res_q.count  <= spq_pkg::COUNT_W'(fill_q - FW'(1));
								state_q      <= ST_POP;
							end
						end
					end
				end
				ST_SHIFT: begin
					if (greater) begin
						pos_q <= pos_q - AW'(1);
						if (pos_q == AW'(1)) begin
							state_q <= ST_PUT;
						end
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_PUT: begin
					state_q <= ST_RESP;
				end
				ST_POP: begin
					res_q.removed_value <= mem_rdata;
					state_q             <= ST_RESP;
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/sorted_array_priority_queue.sv =====
// Top level of the sorted-array maximum priority queue with its output register.
//
// This block is a maximum priority queue of up to CAPACITY (128) signed 32-bit
// values. The values sit in ascending order in a simple dual-port memory with a
// registered read. Each command transfer on the slave stream carries an insert
// (tuser low) or a remove (tuser high) and yields exactly one result transfer on
// the master stream. An insert walks down from the top of the filled region,
// moving every larger entry up by one place and writing the new value above the
// last entry that is less than or equal to it, so equal values keep arrival
// order. An insert into a full queue changes nothing and reports full; a remove
// returns the largest entry, or reports empty with a removed value of zero. The
// count in every result is the number of stored entries after the command,
// taken modulo 256. The shift walk of an insert moves one entry per cycle,
// limited by the one read and one write the memory takes each cycle. One
// command is in flight at a time. The result lands in an output register, so
// the command side is released as soon as that register can take the result:
// when it is empty, or when its current content leaves downstream in that
// cycle. The memory needs no clearing after reset: only entries below the
// count are ever read.
`default_nettype none

module sorted_array_priority_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] value
	input  wire logic [0:0]  s_axis_tuser,   // [0] cmd
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [47:0] m_axis_tdata    // [31:0] removed_value, [33:32] status,
	                                         // [41:34] count, [47:42] zero
);

	spq_pkg::mem_req_t                mem_req;
	logic [spq_pkg::VALUE_W-1:0]      mem_rdata;
	logic                             res_valid;
	logic                             res_ready;
	spq_pkg::result_t                 res;

	logic                             out_valid_q;
	spq_pkg::result_t                 out_q;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_axis_tvalid),
		.cmd_ready (s_axis_tready),
		.cmd       (s_axis_tuser[0]),
		.value     (s_axis_tdata),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	spq_ram #(
		.DEPTH  (spq_pkg::CAPACITY),
		.WIDTH  (spq_pkg::VALUE_W),
		.ADDR_W (spq_pkg::ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	// The output register takes a new result whenever it is empty or its
	// current content leaves in this cycle.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_q.count, out_q.status, out_q.removed_value};

endmodule

`default_nettype wire

// ===== src/spq_checker.sv =====
// Port-level checker of the sorted-array priority queue and its bind.
`default_nettype none

`include "sorted_array_priority_queue_macros.svh"

module spq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [31:0] s_axis_tdata,
	input wire logic [0:0]  s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [47:0] m_axis_tdata
);

	logic       in_xfer;
	logic       out_xfer;
	logic [1:0] status;
	logic [7:0] count;
	logic       bad_status;
	logic       refused;

	assign in_xfer    = s_axis_tvalid && s_axis_tready;
	assign out_xfer   = m_axis_tvalid && m_axis_tready;
	assign status     = m_axis_tdata[33:32];
	assign count      = m_axis_tdata[41:34];
	assign bad_status = (status != 2'(spq_pkg::STATUS_OK)) &&
	                    (status != 2'(spq_pkg::STATUS_FULL)) &&
	                    (status != 2'(spq_pkg::STATUS_EMPTY));
	assign refused    = (status != 2'(spq_pkg::STATUS_OK));

	// Only the three defined status codes ever leave the block.
	`SPQ_ASSERT_NOW(a_status_code, clk, arst_n, m_axis_tvalid, !bad_status,
		"result carries an undefined status code")

	// A refused command removes nothing.
	`SPQ_ASSERT_NOW(a_refused_zero, clk, arst_n, m_axis_tvalid && refused,
		m_axis_tdata[31:0] == 32'd0, "refused command reports a nonzero value")

	// An empty report comes with a count of zero, a full one with the capacity.
	`SPQ_ASSERT_NOW(a_refused_count, clk, arst_n, m_axis_tvalid && refused,
		(status == 2'(spq_pkg::STATUS_EMPTY)) ? (count == 8'd0) :
		(count == 8'(spq_pkg::CAPACITY)), "refused command reports a wrong count")

	// A stalled result stays on the bus unchanged.
	`SPQ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed or dropped")

	// No command is taken in the cycle right after one was taken.
	`SPQ_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_xfer, !s_axis_tready,
		"command accepted while another is still in progress")

	logic unused_ok;
	assign unused_ok = ^{out_xfer, s_axis_tdata, s_axis_tuser};

endmodule

bind sorted_array_priority_queue spq_checker u_spq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench of the sorted-array maximum priority queue.
module tb;

	typedef enum logic [2:0] {
		PH_FREE,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH_IDLE,
		PH_PRESSURE
	} tb_phase_t;

	typedef struct {
		logic                        cmd;
		logic [spq_pkg::VALUE_W-1:0] value;
		tb_phase_t                   phase;
	} queue_command_t;

	// Idle and stall chances in percent, indexed by phase.
	localparam int SEND_IDLE_PCT [5] = '{0, 67, 0, 38, 0};
	localparam int RECV_STALL_PCT [5] = '{0, 0, 67, 38, 0};
	localparam int PRESSURE_HOLD = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = spq_pkg::CAPACITY + 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [31:0] value
	logic [0:0]  s_axis_tuser = '0;   // [0] cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;        // [31:0] removed_value, [33:32] status,
	                                  // [41:34] count, [47:42] zero

	queue_command_t   queued_commands [$];
	spq_pkg::result_t awaited_results [$];
	tb_phase_t        active_phase = PH_FREE;

	// Shadow copy of the queue contents, kept in ascending order.
	logic signed [spq_pkg::VALUE_W-1:0] shadow_store [spq_pkg::CAPACITY];
	int                                 shadow_fill = 0;

	int gen_fill = 0;
	int mismatches = 0;
	int hold_cycles;
	int quiet_cycles;

	sorted_array_priority_queue DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Applies one command to the shadow queue and returns the result it should give.
	function automatic spq_pkg::result_t shadow_queue_apply(input logic cmd,
	                          input logic signed [spq_pkg::VALUE_W-1:0] value);
		spq_pkg::result_t r;
		int               pos;
		r.removed_value = '0;
		r.status = spq_pkg::STATUS_OK;
		if (cmd == spq_pkg::CMD_INSERT) begin
			if (shadow_fill >= spq_pkg::CAPACITY) begin
				r.status = spq_pkg::STATUS_FULL;
			end else begin
				// Walk down past every larger entry so equal values stay in arrival order.
				pos = shadow_fill;
				while (pos > 0 && shadow_store[pos-1] > value) begin
					shadow_store[pos] = shadow_store[pos-1];
					pos--;
				end
				shadow_store[pos] = value;
				shadow_fill++;
			end
		end else begin
			if (shadow_fill == 0) begin
				r.status = spq_pkg::STATUS_EMPTY;
			end else begin
				shadow_fill--;
				r.removed_value = shadow_store[shadow_fill];
			end
		end
		r.count = shadow_fill[spq_pkg::COUNT_W-1:0];
		return r;
	endfunction

	// Mostly full-range values, with a share of tiny values for ties and the extremes.
	function automatic logic [spq_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(7))
			0, 1: return 32'(int'($urandom_range(8)) - 4);
			2: begin
				case ($urandom_range(3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	task automatic enqueue_command(input logic cmd, input logic [spq_pkg::VALUE_W-1:0] value,
	                               input tb_phase_t phase);
		queue_command_t c;
		c.cmd = cmd;
		c.value = value;
		c.phase = phase;
		queued_commands.push_back(c);
		if (cmd == spq_pkg::CMD_INSERT && gen_fill < spq_pkg::CAPACITY)
			gen_fill++;
		else if (cmd == spq_pkg::CMD_REMOVE && gen_fill > 0)
			gen_fill--;
	endtask

	task automatic enqueue_mix(input int n, input int insert_pct, input tb_phase_t phase);
		repeat (n) begin
			if ($urandom_range(99) < insert_pct)
				enqueue_command(spq_pkg::CMD_INSERT, pick_value(), phase);
			else
				enqueue_command(spq_pkg::CMD_REMOVE, pick_value(), phase);
		end
	endtask

	// Command driver: a new transfer is offered once the previous one has gone.
	always @(posedge clk or negedge arst_n) begin
		queue_command_t cmd_item;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				awaited_results.push_back(shadow_queue_apply(s_axis_tuser[0], s_axis_tdata));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (queued_commands.size() != 0 &&
				    $urandom_range(99) >= SEND_IDLE_PCT[queued_commands[0].phase]) begin
					cmd_item = queued_commands.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= cmd_item.value;
					s_axis_tuser <= cmd_item.cmd;
					active_phase <= cmd_item.phase;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks every transfer against the oldest awaited result.
	always @(posedge clk or negedge arst_n) begin
		spq_pkg::result_t got;
		spq_pkg::result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[41:0];
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h",
					         $time, m_axis_tdata);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (got.removed_value !== want.removed_value) begin
						$display("%0t: removed_value expected %h got %h",
						         $time, want.removed_value, got.removed_value);
						mismatches++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d got %0d",
						         $time, want.status, got.status);
						mismatches++;
					end
					if (got.count !== want.count) begin
						$display("%0t: count expected %0d got %0d",
						         $time, want.count, got.count);
						mismatches++;
					end
					if (m_axis_tdata[47:42] !== '0) begin
						$display("%0t: padding expected 0 got %h", $time, m_axis_tdata[47:42]);
						mismatches++;
					end
				end
			end
			// Under pressure the receiver holds off long enough for the block to
			// fill its output register and refuse further commands.
			if (active_phase == PH_PRESSURE && hold_cycles < PRESSURE_HOLD) begin
				m_axis_tready <= 1'b0;
				hold_cycles <= hold_cycles + 1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= RECV_STALL_PCT[active_phase]);
			end
		end
	end

	// Watchdog on cycles without any transfer on either side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles < WATCHDOG_LIMIT) begin
			quiet_cycles <= quiet_cycles + 1;
		end else begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		// Directed opening: remove on empty, extremes, ties, then drain past empty.
		enqueue_command(spq_pkg::CMD_REMOVE, pick_value(), PH_FREE);
		enqueue_command(spq_pkg::CMD_INSERT, 32'h7FFF_FFFF, PH_FREE);
		enqueue_command(spq_pkg::CMD_INSERT, 32'h8000_0000, PH_FREE);
		enqueue_command(spq_pkg::CMD_INSERT, 32'h0000_0000, PH_FREE);
		enqueue_command(spq_pkg::CMD_INSERT, 32'hFFFF_FFFF, PH_FREE);
		enqueue_command(spq_pkg::CMD_INSERT, 32'd5, PH_FREE);
		enqueue_command(spq_pkg::CMD_INSERT, 32'd5, PH_FREE);
		enqueue_command(spq_pkg::CMD_INSERT, 32'hFFFF_FFFF, PH_FREE);
		enqueue_command(spq_pkg::CMD_INSERT, 32'd1, PH_FREE);
		repeat (3) enqueue_command(spq_pkg::CMD_REMOVE, pick_value(), PH_FREE);
		enqueue_command(spq_pkg::CMD_INSERT, 32'h7FFF_FFFF, PH_FREE);
		enqueue_command(spq_pkg::CMD_INSERT, 32'h8000_0000, PH_FREE);
		repeat (8) enqueue_command(spq_pkg::CMD_REMOVE, pick_value(), PH_FREE);

		enqueue_mix(100, 60, PH_FREE);

		// Fill to capacity and push against the full queue.
		while (gen_fill < spq_pkg::CAPACITY)
			enqueue_command(spq_pkg::CMD_INSERT, pick_value(), PH_SEND_IDLE);
		repeat (3) enqueue_command(spq_pkg::CMD_INSERT, pick_value(), PH_SEND_IDLE);
		enqueue_mix(10, 50, PH_SEND_IDLE);

		// Drain completely and keep removing on the empty queue.
		while (gen_fill > 0)
			enqueue_command(spq_pkg::CMD_REMOVE, pick_value(), PH_RECV_STALL);
		repeat (3) enqueue_command(spq_pkg::CMD_REMOVE, pick_value(), PH_RECV_STALL);
		enqueue_mix(10, 50, PH_RECV_STALL);

		enqueue_mix(150, 55, PH_BOTH_IDLE);
		enqueue_mix(116, 70, PH_PRESSURE);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (queued_commands.size() != 0 || s_axis_tvalid || awaited_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
